// ----- rtl/fit_policy_block_allocator_core_defines.svh -----
// Assertion macros shared by the allocator checker.
// No dependencies; included by bare file name.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define FPBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpba check failed");

// Next-cycle implication, also checked through reset.
`define FPBA_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fpba check failed");

`endif

// ----- rtl/fpba_pkg.sv -----
// Shared types and constants for the fit-policy block allocator.
// No dependencies.
package fpba_pkg;

    localparam int SIZE_W          = 15;
    localparam int IDX_FIELD_W     = 6;
    localparam int MODE_W          = 2;
    localparam int COUNT_W         = 7;
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;
    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic REG_FIT_MODE    = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic                   req_type;
        logic [IDX_FIELD_W-1:0] entry_index;
        logic [SIZE_W-1:0]      amount;
    } t_in_item;

    typedef struct packed {
        logic                   granted;
        logic [IDX_FIELD_W-1:0] chosen_index;
        logic [SIZE_W-1:0]      remaining;
    } t_out_item;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic                   is_alloc;
        logic                   in_range;
        logic [IDX_FIELD_W-1:0] entry_index;
        logic [SIZE_W-1:0]      amount;
    } t_op;

    typedef struct packed {
        logic [MODE_W-1:0]  fit_mode;
        logic [COUNT_W-1:0] block_count;
    } t_cfg;

endpackage

// ----- rtl/fit_policy_block_allocator_core.sv -----
// Fit-policy block allocator. Load item: queued, then written to the table once the back end
// is idle. Request item: once the back end is free, it scans N entries, N = active block count,
// reading one table entry per cycle from a single-port memory, then registers the result and
// strobe in its write-back state; it pops no new item until that write-back is done.
// A two-item queue lets start be taken while a scan runs. Synchronous reset clears
// control and registers (fit mode first fit, block count 64); table is unset.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_strobe,
    output t_out_item         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    logic op_valid;
    t_op  op;
    logic pop;

    fpba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fpba_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_pop      (pop)
    );

    fpba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/fpba_cfg.sv -----
// APB-style register file: fit mode and block count.
// Depends on fpba_pkg.
module fpba_cfg
    import fpba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [MODE_W-1:0]  r_fit_mode;
    logic [COUNT_W-1:0] r_block_count;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= MODE_FIRST;
            r_block_count <= BLOCK_COUNT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FIT_MODE:    r_fit_mode    <= pwdata[MODE_W-1:0];
                REG_BLOCK_COUNT: r_block_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FIT_MODE:    prdata = DATA_W'(r_fit_mode);
            REG_BLOCK_COUNT: prdata = DATA_W'(r_block_count);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.fit_mode    = r_fit_mode;
    assign o_cfg.block_count = r_block_count;

endmodule

// ----- rtl/fpba_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on fpba_pkg.
module fpba_front
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    output logic     o_busy,
    output logic     o_op_valid,
    output t_op      o_op,
    input  logic     i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;
    t_op              op_in;

    assign o_busy     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_op_valid = (r_count != '0);
    assign push       = i_start && !o_busy;
    assign pop        = i_pop && o_op_valid;

    always_comb begin
        op_in.is_alloc    = (i_item.req_type == REQ_ALLOC);
        op_in.in_range    = (int'(i_item.entry_index) < MAX_BLOCKS);
        op_in.entry_index = i_item.entry_index;
        op_in.amount      = i_item.amount;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= op_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_op = r_queue[r_rd_ptr];

endmodule

// ----- rtl/fpba_back.sv -----
// Back end: size table, per-request scan engine and write-back.
// Depends on fpba_pkg.
module fpba_back
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_op_valid,
    input  t_op       i_op,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    t_state            r_state;
    logic [SIZE_W-1:0] r_mem [MAX_BLOCKS];
    logic [SIZE_W-1:0] r_rd_data;
    logic [SIZE_W-1:0] r_amount;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_issue;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_pick;
    logic [SIZE_W-1:0] r_best;
    logic              r_strobe;
    t_out_item         r_result;

    logic [CNT_W-1:0]  act_count;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              fits;
    logic              take;
    logic [SIZE_W-1:0] left;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] wr_data;

    // Counts above the table depth saturate.
    assign act_count = (int'(i_cfg.block_count) > MAX_BLOCKS) ?
                       CNT_W'(MAX_BLOCKS) : CNT_W'(i_cfg.block_count);

    assign o_pop   = (r_state == S_IDLE) && i_op_valid;
    assign rd_en   = (r_state == S_SCAN) && (r_issue < r_count);
    assign rd_addr = r_issue[IDX_W-1:0];
    assign fits    = (r_rd_data >= r_amount);
    assign left    = r_best - r_amount;

    // Strict compares keep the lowest index on a tie.
    always_comb begin
        take = 1'b0;
        if (r_cmp_vld && fits) begin
            unique case (i_cfg.fit_mode)
                MODE_BEST:  take = !r_found || (r_rd_data < r_best);
                MODE_WORST: take = !r_found || (r_rd_data > r_best);
                default:    take = !r_found;
            endcase
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = IDX_W'(i_op.entry_index);
        wr_data = i_op.amount;
        if (r_state == S_WRITE) begin
            wr_en   = r_found;
            wr_addr = r_pick;
            wr_data = left;
        end else if (o_pop && !i_op.is_alloc) begin
            wr_en = i_op.in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_issue   <= '0;
        end else begin
            r_strobe  <= 1'b0;
            r_cmp_vld <= rd_en;
            r_cmp_idx <= rd_addr;
            if (take) begin
                r_found <= 1'b1;
                r_pick  <= r_cmp_idx;
                r_best  <= r_rd_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_op.is_alloc) begin
                        r_amount <= i_op.amount;
                        r_count  <= act_count;
                        r_issue  <= '0;
                        r_found  <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Leave only once the last read has been compared.
                    if (rd_en) begin
                        r_issue <= r_issue + 1'b1;
                    end else if (!r_cmp_vld) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_strobe <= 1'b1;
                    if (r_found) begin
                        r_result.granted      <= 1'b1;
                        r_result.chosen_index <= IDX_FIELD_W'(r_pick);
                        r_result.remaining    <= left;
                    end else begin
                        r_result <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/fpba_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
// Depends on fpba_pkg and fit_policy_block_allocator_core_defines.svh.
`include "fit_policy_block_allocator_core_defines.svh"

module fpba_checker
    import fpba_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);

    // A failed request reports zero index and zero size.
    `FPBA_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, o_strobe && !o_result.granted, o_result.chosen_index == '0 && o_result.remaining == '0)

    // Each request needs at least a pop, scan and write-back, so no two strobes in a row.
    `FPBA_ASSERT_NEXT(a_strobe_pulse, i_clk, o_strobe, !o_strobe)

    // Reset empties the queue and drops any pending result.
    `FPBA_ASSERT_NEXT(a_reset_clear, i_clk, !i_rst_n, !o_strobe && !busy)

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- verif/tb.sv -----
// Self-checking testbench for fit_policy_block_allocator_core: directed and random
// load and request items under each fit mode and several block counts, checked by a local model.
// Depends on fpba_pkg and the allocator core RTL.
module tb;
    import fpba_pkg::*;

    localparam int TB_BLOCKS     = DEF_MAX_BLOCKS;
    localparam int SETTLE_CYCLES = 2 * (TB_BLOCKS + 4) + 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 160;

    localparam logic [MODE_W-1:0] MODE_UNDEF       = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_FIT_MODE    = {REG_FIT_MODE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_BLOCK_COUNT = {REG_BLOCK_COUNT, 2'b00};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in_item          i_item;
    logic              o_strobe;
    t_out_item         o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // local copy of the allocator state
    logic [SIZE_W-1:0]  free_size_tbl [TB_BLOCKS];
    logic [MODE_W-1:0]  mode_cfg;
    logic [COUNT_W-1:0] count_cfg;

    t_out_item pending_grants[$];
    int        mismatch_count = 0;
    int        stall_cycles   = 0;

    fit_policy_block_allocator_core #(
        .MAX_BLOCKS(TB_BLOCKS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int active_blocks();
        return (int'(count_cfg) > TB_BLOCKS) ? TB_BLOCKS : int'(count_cfg);
    endfunction

    // Applies one item to the local table; a request yields the expected grant.
    function automatic void model_allocate(input t_in_item it, output bit has_res,
                                           output t_out_item res);
        int  n;
        int  pick;
        bit  found;
        n       = active_blocks();
        pick    = 0;
        found   = 1'b0;
        has_res = 1'b0;
        res     = '0;
        if (it.req_type == REQ_LOAD) begin
            free_size_tbl[it.entry_index] = it.amount;
            return;
        end
        for (int t = 0; t < n; t++) begin
            if (free_size_tbl[t] >= it.amount) begin
                case (mode_cfg)
                    MODE_BEST: begin
                        if (!found || free_size_tbl[t] < free_size_tbl[pick]) pick = t;
                    end
                    MODE_WORST: begin
                        if (!found || free_size_tbl[t] > free_size_tbl[pick]) pick = t;
                    end
                    default: begin
                        if (!found) pick = t;
                    end
                endcase
                found = 1'b1;
            end
        end
        has_res = 1'b1;
        if (found) begin
            free_size_tbl[pick] = free_size_tbl[pick] - it.amount;
            res.granted         = 1'b1;
            res.chosen_index    = pick[IDX_FIELD_W-1:0];
            res.remaining       = free_size_tbl[pick];
        end
    endfunction

    function automatic t_in_item mk_item(input logic kind, input int idx, input int amt);
        t_in_item it;
        it.req_type    = kind;
        it.entry_index = idx[IDX_FIELD_W-1:0];
        it.amount      = amt[SIZE_W-1:0];
        return it;
    endfunction

    // Mostly requests aimed at sizes actually in the table, plus loads and noise.
    function automatic t_in_item rand_item();
        t_in_item it;
        int       n;
        int       pick;
        int       roll;
        int       sz;
        n    = active_blocks();
        pick = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, TB_BLOCKS - 1);
        roll = $urandom_range(0, 99);
        it.req_type    = 1'($urandom_range(0, 1));
        it.entry_index = IDX_FIELD_W'($urandom_range(0, TB_BLOCKS - 1));
        it.amount      = SIZE_W'($urandom_range(0, 32767));
        if (roll < 6) begin
            return it;
        end else if (roll < 42) begin
            it.req_type = REQ_LOAD;
            if ($urandom_range(0, 3) != 0) it.entry_index = pick[IDX_FIELD_W-1:0];
            case ($urandom_range(0, 4))
                0:       it.amount = '0;
                1:       it.amount = '1;
                2:       it.amount = SIZE_W'($urandom_range(0, 255));
                default: ;
            endcase
        end else begin
            it.req_type = REQ_ALLOC;
            sz = int'(free_size_tbl[pick]);
            case ($urandom_range(0, 6))
                0:       it.amount = '0;
                1, 2:    it.amount = SIZE_W'(sz);
                3, 4:    it.amount = SIZE_W'($urandom_range(0, sz));
                5:       it.amount = SIZE_W'((sz < 32767) ? sz + 1 : sz);
                default: ;
            endcase
        end
        return it;
    endfunction

    // Leaves start high; the caller lowers it through idle_cycles or wait_for_results.
    task automatic send_item(input t_in_item it);
        bit        has_res;
        t_out_item res;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        model_allocate(it, has_res, res);
        if (has_res) pending_grants.push_back(res);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    // Loads give no result, so allow the queue and any scan to finish too.
    task automatic quiesce();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input int unsigned data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_FIT_MODE) mode_cfg = data[MODE_W-1:0];
        else count_cfg = data[COUNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input int count);
        quiesce();
        write_reg(ADDR_FIT_MODE, 32'(mode));
        write_reg(ADDR_BLOCK_COUNT, count);
    endtask

    // Every entry is written before any request scans it.
    task automatic test_table_load();
        int sz;
        for (int i = 0; i < TB_BLOCKS; i++) begin
            sz = 500;
            if (i == 5 || i == 10) sz = 40;
            if (i == TB_BLOCKS - 1) sz = 32767;
            send_item(mk_item(REQ_LOAD, i, sz));
        end
    endtask

    // Runs under the reset configuration: first fit over all entries.
    task automatic test_first_fit();
        send_item(mk_item(REQ_ALLOC, 0, 0));
        send_item(mk_item(REQ_ALLOC, 63, 32767));
        send_item(mk_item(REQ_ALLOC, 0, 32767));
        send_item(mk_item(REQ_ALLOC, 0, 500));
        send_item(mk_item(REQ_ALLOC, 0, 1));
    endtask

    task automatic test_best_fit();
        set_config(MODE_BEST, TB_BLOCKS);
        send_item(mk_item(REQ_ALLOC, 0, 40));   // tie between two entries
        send_item(mk_item(REQ_ALLOC, 0, 40));
        send_item(mk_item(REQ_ALLOC, 0, 1));
        send_item(mk_item(REQ_ALLOC, 0, 32767));
    endtask

    task automatic test_worst_fit();
        set_config(MODE_WORST, TB_BLOCKS);
        send_item(mk_item(REQ_LOAD, 63, 32767));
        send_item(mk_item(REQ_LOAD, 20, 32767));
        send_item(mk_item(REQ_ALLOC, 0, 1));
        send_item(mk_item(REQ_ALLOC, 0, 1));
        send_item(mk_item(REQ_ALLOC, 0, 32766));
    endtask

    task automatic test_mode_and_count_edges();
        set_config(MODE_UNDEF, TB_BLOCKS);
        send_item(mk_item(REQ_ALLOC, 0, 2));
        set_config(MODE_FIRST, 127);            // saturates to the table size
        send_item(mk_item(REQ_ALLOC, 0, 32766));
        set_config(MODE_BEST, 0);               // nothing scanned, always refused
        send_item(mk_item(REQ_ALLOC, 0, 0));
        set_config(MODE_FIRST, 1);
        send_item(mk_item(REQ_ALLOC, 0, 0));
        send_item(mk_item(REQ_ALLOC, 0, 1));
    endtask

    task automatic run_random_phase(input logic [MODE_W-1:0] mode, input int count,
                                    input bit with_gaps);
        set_config(mode, count);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_item(rand_item());
            if (with_gaps && ((k / 40) % 3 != 2) && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 5));
            else if ($urandom_range(0, 149) == 0)
                wait_for_results();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(MODE_FIRST, TB_BLOCKS, 1'b1);
        run_random_phase(MODE_BEST,  TB_BLOCKS, 1'b1);
        run_random_phase(MODE_WORST, TB_BLOCKS, 1'b1);
        run_random_phase(MODE_UNDEF, 33, 1'b1);
        run_random_phase(MODE_BEST,  1, 1'b1);
        run_random_phase(MODE_WORST, 127, 1'b1);
        run_random_phase(MODE_FIRST, 0, 1'b1);
        run_random_phase(MODE_BEST,  $urandom_range(2, TB_BLOCKS), 1'b1);
        run_random_phase(MODE_WORST, $urandom_range(2, TB_BLOCKS), 1'b1);
        run_random_phase(MODE_FIRST, 100, 1'b1);
        run_random_phase(MODE_BEST,  8, 1'b1);
        run_random_phase(MODE_WORST, TB_BLOCKS, 1'b0);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_result);
                mismatch_count++;
            end else begin
                want = pending_grants.pop_front();
                if (o_result.granted !== want.granted) begin
                    $display("%0t: granted expected %0d actual %0d",
                             $time, want.granted, o_result.granted);
                    mismatch_count++;
                end
                if (o_result.chosen_index !== want.chosen_index) begin
                    $display("%0t: chosen_index expected %0d actual %0d",
                             $time, want.chosen_index, o_result.chosen_index);
                    mismatch_count++;
                end
                if (o_result.remaining !== want.remaining) begin
                    $display("%0t: remaining expected %0d actual %0d",
                             $time, want.remaining, o_result.remaining);
                    mismatch_count++;
                end
            end
        end
    end

    // cycles with neither an item taken, a result given nor a register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || psel) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_item    <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        mode_cfg  = MODE_FIRST;
        count_cfg = BLOCK_COUNT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_first_fit();
        test_best_fit();
        test_worst_fit();
        test_mode_and_count_edges();
        test_random_traffic();

        quiesce();
        if (mismatch_count == 0 && pending_grants.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fpba_pkg.sv
rtl/fpba_cfg.sv
rtl/fpba_front.sv
rtl/fpba_back.sv
rtl/fit_policy_block_allocator_core.sv
rtl/fpba_checker.sv
verif/tb.sv
